FILE: rtl/core/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion shorthands for the checker modules.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/ncm_pkg.sv
// ============================================================================
// ncm_pkg
// Shared types and constants for the nested comment masker.
// ============================================================================
package ncm_pkg;

  // Counter widths inside the scanner.
  localparam int NEST_BITS   = 16;
  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;

  // Widths of the error position fields on the result channel.
  localparam int LINE_W = 20;
  localparam int COL_W  = 16;

  // Result tdata packing: masked byte, error line, error column.
  localparam int OUT_FIELDS_W = 8 + LINE_W + COL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 2;

  // Run queue between the scanner and the output serializer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Character codes.
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // One input transaction's results: one or two bytes plus end flags.
  typedef struct packed {
    logic              two_bytes;
    logic [7:0]        byte0;
    logic [7:0]        byte1;
    logic              fin;
    logic              err;
    logic [LINE_W-1:0] err_line;
    logic [COL_W-1:0]  err_col;
  } run_t;

  // Queue status seen by the serializer.
  typedef struct packed {
    logic empty;
    run_t head;
  } queue_stat_t;

endpackage

FILE: rtl/core/ncm_queue.sv
// ============================================================================
// ncm_queue
// Small register queue of result runs between the scanner and the serializer.
// ============================================================================
module ncm_queue
  import ncm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  run_t        push_run,
  output logic        full,
  input  logic        pop,
  output queue_stat_t stat
);

  run_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.head  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

FILE: rtl/core/ncm_front.sv
// ============================================================================
// ncm_front
// Scanner: accepts source bytes, tracks the comment mode and position, and
// turns each input transaction into a run of zero, one or two result bytes.
// ============================================================================
module ncm_front
  import ncm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  input  logic       queue_full,
  output logic       in_ready,
  output logic       push,
  output run_t       push_run
);

  typedef enum logic [3:0] {
    MODE_CODE   = 4'b0001,
    MODE_STRING = 4'b0010,
    MODE_LINE   = 4'b0100,
    MODE_BLOCK  = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t                  mode;
    logic [NEST_BITS-1:0]   depth;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [LINE_BITS-1:0]   open_line;
    logic [COLUMN_BITS-1:0] open_col;
  } scan_st_t;

  typedef struct packed {
    scan_st_t   st;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } scan_res_t;

  localparam scan_st_t ST_RESET = '{
    mode:      MODE_CODE,
    depth:     '0,
    line:      LINE_BITS'(1),
    col:       COLUMN_BITS'(1),
    open_line: LINE_BITS'(1),
    open_col:  COLUMN_BITS'(1)
  };

  // Saturating column advance by one or two.
  function automatic logic [COLUMN_BITS-1:0] col_add(logic [COLUMN_BITS-1:0] col,
                                                      logic two);
    logic [COLUMN_BITS:0] s;
    s = {1'b0, col} + (two ? (COLUMN_BITS+1)'(2) : (COLUMN_BITS+1)'(1));
    if (s[COLUMN_BITS]) begin
      return '1;
    end
    return s[COLUMN_BITS-1:0];
  endfunction

  // Saturating line advance.
  function automatic logic [LINE_BITS-1:0] line_inc(logic [LINE_BITS-1:0] line);
    if (line == '1) begin
      return line;
    end
    return line + LINE_BITS'(1);
  endfunction

  // One scan step on byte c with an optional lookahead byte.
  function automatic scan_res_t scan_byte(scan_st_t st, logic [7:0] c,
                                          logic has_next, logic [7:0] nx);
    scan_res_t r;
    r.st  = st;
    r.two = 1'b0;
    r.b0  = c;
    r.b1  = nx;
    unique case (st.mode)
      MODE_CODE: begin
        if (c == CH_QUOTE) begin
          r.st.mode = MODE_STRING;
          r.st.col  = col_add(st.col, 1'b0);
        end else if (c == CH_SLASH && has_next && (nx == CH_SLASH || nx == CH_STAR)) begin
          r.two    = 1'b1;
          r.b0     = CH_SPACE;
          r.b1     = CH_SPACE;
          r.st.col = col_add(st.col, 1'b1);
          if (nx == CH_STAR) begin
            r.st.mode      = MODE_BLOCK;
            r.st.depth     = NEST_BITS'(1);
            r.st.open_line = st.line;
            r.st.open_col  = st.col;
          end else begin
            r.st.mode = MODE_LINE;
          end
        end else if (c == CH_NL) begin
          r.st.line = line_inc(st.line);
          r.st.col  = COLUMN_BITS'(1);
        end else begin
          r.st.col = col_add(st.col, 1'b0);
        end
      end
      MODE_STRING: begin
        if (c == CH_BSLASH && has_next) begin
          // Escaped byte passes through; with its backslash it counts as two columns.
          r.two    = 1'b1;
          r.st.col = col_add(st.col, 1'b1);
        end else begin
          if (c == CH_QUOTE) begin
            r.st.mode = MODE_CODE;
          end
          if (c == CH_NL) begin
            r.st.line = line_inc(st.line);
            r.st.col  = COLUMN_BITS'(1);
          end else begin
            r.st.col = col_add(st.col, 1'b0);
          end
        end
      end
      MODE_LINE: begin
        if (c == CH_NL) begin
          r.st.mode = MODE_CODE;
          r.st.line = line_inc(st.line);
          r.st.col  = COLUMN_BITS'(1);
        end else begin
          r.b0     = CH_SPACE;
          r.st.col = col_add(st.col, 1'b0);
        end
      end
      MODE_BLOCK: begin
        if (c == CH_SLASH && has_next && nx == CH_STAR) begin
          r.two = 1'b1;
          r.b0  = CH_SPACE;
          r.b1  = CH_SPACE;
          r.st.col = col_add(st.col, 1'b1);
          if (st.depth != '1) begin
            r.st.depth = st.depth + NEST_BITS'(1);
          end
        end else if (c == CH_STAR && has_next && nx == CH_SLASH) begin
          r.two = 1'b1;
          r.b0  = CH_SPACE;
          r.b1  = CH_SPACE;
          r.st.col = col_add(st.col, 1'b1);
          if (st.depth != '0) begin
            r.st.depth = st.depth - NEST_BITS'(1);
          end
          if (r.st.depth == '0) begin
            r.st.mode = MODE_CODE;
          end
        end else if (c == CH_NL) begin
          r.st.line = line_inc(st.line);
          r.st.col  = COLUMN_BITS'(1);
        end else begin
          r.b0     = CH_SPACE;
          r.st.col = col_add(st.col, 1'b0);
        end
      end
      default: begin
        r.st.mode = MODE_CODE;
      end
    endcase
    return r;
  endfunction

  // Saturate the error position to the result field widths.
  function automatic logic [LINE_W-1:0] sat_line(logic [LINE_BITS-1:0] v);
    logic [32:0] ext;
    ext = 33'(v);
    if (ext > 33'({LINE_W{1'b1}})) begin
      return '1;
    end
    return LINE_W'(ext);
  endfunction

  function automatic logic [COL_W-1:0] sat_col(logic [COLUMN_BITS-1:0] v);
    logic [32:0] ext;
    ext = 33'(v);
    if (ext > 33'({COL_W{1'b1}})) begin
      return '1;
    end
    return COL_W'(ext);
  endfunction

  scan_st_t   st_r, st_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;

  scan_res_t  p1, p2;
  scan_st_t   st_a, st_f;
  logic       pend_valid;
  logic [1:0] cnt;
  logic       accept;
  logic       err;

  assign in_ready = !queue_full;
  assign accept   = in_valid && !queue_full;

  // Two chained scan steps: the held byte with lookahead, then on the last
  // byte the still pending byte with no lookahead.
  always_comb begin
    p1         = scan_byte(st_r, held_byte_r, 1'b1, in_byte);
    st_a       = st_r;
    pend_valid = 1'b1;
    cnt        = 2'd0;
    push_run   = '0;
    if (held_valid_r) begin
      st_a           = p1.st;
      push_run.byte0 = p1.b0;
      push_run.byte1 = p1.b1;
      cnt            = p1.two ? 2'd2 : 2'd1;
      pend_valid     = !p1.two;
    end
    p2   = scan_byte(st_a, in_byte, 1'b0, 8'h00);
    st_f = st_a;
    if (in_final && pend_valid) begin
      st_f = p2.st;
      if (cnt == 2'd0) begin
        push_run.byte0 = p2.b0;
      end else begin
        push_run.byte1 = p2.b0;
      end
      cnt = cnt + 2'd1;
    end
    err                = in_final && (st_f.mode == MODE_BLOCK);
    push_run.two_bytes = (cnt == 2'd2);
    push_run.fin       = in_final;
    push_run.err       = err;
    push_run.err_line  = err ? sat_line(st_f.open_line) : '0;
    push_run.err_col   = err ? sat_col(st_f.open_col) : '0;
    push               = accept && (cnt != 2'd0);
  end

  // Next scanner state; the last byte returns the scanner state to reset values and drops the held byte.
  always_comb begin
    st_nxt         = st_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    if (accept) begin
      if (in_final) begin
        st_nxt         = ST_RESET;
        held_valid_nxt = 1'b0;
      end else begin
        st_nxt         = st_f;
        held_byte_nxt  = in_byte;
        held_valid_nxt = pend_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_RESET;
      held_valid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
  end

endmodule

FILE: rtl/core/ncm_back.sv
// ============================================================================
// ncm_back
// Serializer: pops runs from the queue and drives one result byte per
// transaction from an output register.
// ============================================================================
module ncm_back
  import ncm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  queue_stat_t       stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              out_done,
  output logic              out_err,
  output logic [LINE_W-1:0] out_line,
  output logic [COL_W-1:0]  out_col
);

  logic              valid_r, valid_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              done_r, done_nxt;
  logic              err_r, err_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              sec_pend_r, sec_pend_nxt;
  run_t              sec_run_r, sec_run_nxt;
  logic              load;

  assign load = !valid_r || out_ready;

  // Pick the next result: a pending second byte first, else the queue head.
  always_comb begin
    valid_nxt    = valid_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    done_nxt     = done_r;
    err_nxt      = err_r;
    line_nxt     = line_r;
    col_nxt      = col_r;
    sec_pend_nxt = sec_pend_r;
    sec_run_nxt  = sec_run_r;
    pop          = 1'b0;
    if (load) begin
      if (sec_pend_r) begin
        valid_nxt    = 1'b1;
        byte_nxt     = sec_run_r.byte1;
        last_nxt     = 1'b1;
        done_nxt     = sec_run_r.fin;
        err_nxt      = sec_run_r.err;
        line_nxt     = sec_run_r.err_line;
        col_nxt      = sec_run_r.err_col;
        sec_pend_nxt = 1'b0;
      end else if (!stat.empty) begin
        pop          = 1'b1;
        valid_nxt    = 1'b1;
        byte_nxt     = stat.head.byte0;
        last_nxt     = !stat.head.two_bytes;
        done_nxt     = stat.head.fin && !stat.head.two_bytes;
        err_nxt      = stat.head.err && !stat.head.two_bytes;
        line_nxt     = stat.head.two_bytes ? '0 : stat.head.err_line;
        col_nxt      = stat.head.two_bytes ? '0 : stat.head.err_col;
        sec_pend_nxt = stat.head.two_bytes;
        sec_run_nxt  = stat.head;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      sec_pend_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      sec_pend_r <= sec_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    last_r    <= last_nxt;
    done_r    <= done_nxt;
    err_r     <= err_nxt;
    line_r    <= line_nxt;
    col_r     <= col_nxt;
    sec_run_r <= sec_run_nxt;
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_done  = done_r;
  assign out_err   = err_r;
  assign out_line  = line_r;
  assign out_col   = col_r;

endmodule

FILE: rtl/core/nested_comment_masker.sv
// ============================================================================
// nested_comment_masker
// Masks comment text in a byte stream, with nested block comments.
// ============================================================================
// Input channel in_*: one source byte per transaction in in_tdata; in_tlast
// marks the last byte of the source. Result channel out_*: one output byte
// per transaction, comment bytes replaced by a space and newlines kept.
// out_tlast marks the last result caused by one input byte, out_tuser[0]
// the last result of the source and out_tuser[1] a source that ended inside
// a block comment; the opening line and column of that comment then stand
// in out_tdata, otherwise those fields are zero.
// An input byte gives zero, one or two results, since two-character markers
// are resolved with one byte of lookahead; the last byte flushes the pending
// one. Every source byte yields exactly one result byte, so the scanner and
// the serializer both sustain one byte per cycle back to back while out_tready
// stays high; the run queue absorbs the transactions that give two results.
// The first result of an input transaction is written into the four-entry run
// queue at the accepting edge and reaches the result channel from the output
// register.
// Reset (rst_n low, synchronous) clears the queue, the output valid flag and
// the scanner state. When the receiver stalls, the output holds its result,
// the queue fills and in_tready drops once it is full.
// ============================================================================
module nested_comment_masker
  import ncm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] text_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] masked_byte, [27:8] error_line,
                                             // [43:28] error_column, rest zero
  output logic                   out_tlast,
  output logic [OUT_TUSER_W-1:0] out_tuser   // [0] stream_done, [1] open_comment_error
);

  logic              queue_full;
  logic              push;
  run_t              push_run;
  logic              pop;
  queue_stat_t       stat;
  logic [7:0]        res_byte;
  logic              res_done;
  logic              res_err;
  logic [LINE_W-1:0] res_line;
  logic [COL_W-1:0]  res_col;

  // Scanner.
  ncm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_final   (in_tlast),
    .queue_full (queue_full),
    .in_ready   (in_tready),
    .push       (push),
    .push_run   (push_run)
  );

  // Run queue.
  ncm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .full     (queue_full),
    .pop      (pop),
    .stat     (stat)
  );

  // Output serializer.
  ncm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (res_byte),
    .out_last  (out_tlast),
    .out_done  (res_done),
    .out_err   (res_err),
    .out_line  (res_line),
    .out_col   (res_col)
  );

  // Pack the result fields.
  assign out_tdata = OUT_TDATA_W'({res_col, res_line, res_byte});
  assign out_tuser = {res_err, res_done};

endmodule

FILE: rtl/core/ncm_checker.sv
// ============================================================================
// ncm_checker
// Port-level checks on the result channel of the comment masker.
// ============================================================================
`include "assert_macros.svh"

module ncm_checker
  import ncm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  logic out_shown;

  assign out_shown = out_tvalid;

  // The end of the source is always the end of a run.
  `ASSERT_SAME(a_done_is_last, clk, rst_n, out_shown && out_tuser[0], out_tlast)

  // An open comment is only reported with the end of the source.
  `ASSERT_SAME(a_err_with_done, clk, rst_n, out_shown && out_tuser[1], out_tuser[0])

  // Error position fields are zero unless an error is reported.
  `ASSERT_SAME(a_pos_zero, clk, rst_n, out_shown && !out_tuser[1], out_tdata[OUT_TDATA_W-1:8] == '0)

  // A reported comment position starts on line one or later.
  `ASSERT_SAME(a_line_valid, clk, rst_n, out_shown && out_tuser[1], out_tdata[27:8] != '0)

  // A stalled result stays on the bus unchanged.
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_shown && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind nested_comment_masker ncm_checker u_ncm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
